// ===== rtl/hcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types and constants for the head/tail checksum deframer.
// ----------------------------------------------------------------------------
package hcd_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int ERR_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);
  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2,
    PH_TAIL    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_LOAD = 2'd2
  } back_state_t;

  // Write into the payload store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // One verified frame waiting to be drained.
  typedef struct packed {
    logic [LEN_W-1:0] count;
    logic [ERR_W-1:0] errors;
  } cmd_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ===== rtl/hcd_front.sv =====
// ----------------------------------------------------------------------------
// hcd_front
// Accepts received bytes, tracks the frame phase, checks sum and tail,
// writes payload bytes to the store and queues verified frames.
// ----------------------------------------------------------------------------
module hcd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [hcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                   cfg_data,
  input  logic                         rx_valid,
  output logic                         rx_stall,
  input  logic [7:0]                   rx_byte,
  input  hcd_pkg::queue_status_t       q_status,
  input  logic                         back_busy,
  output logic                         push,
  output hcd_pkg::cmd_t                push_cmd,
  output hcd_pkg::store_wr_t           store_wr
);
  import hcd_pkg::*;

  logic [7:0]       head_byte;
  logic [7:0]       tail_byte;
  logic [LEN_W-1:0] payload_length;

  phase_t           phase;
  phase_t           phase_next;
  logic [LEN_W-1:0] byte_count;
  logic [LEN_W-1:0] count_inc;
  logic [LEN_W-1:0] eff_length;
  logic [7:0]       running_sum;
  logic             sum_ok;
  logic [ERR_W-1:0] errors_seen;
  logic             accept;
  logic             frame_good;
  logic             count_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte      <= 8'd165;
      tail_byte      <= 8'd90;
      payload_length <= LEN_W'(8);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEAD_BYTE:      head_byte      <= cfg_data;
        REG_TAIL_BYTE:      tail_byte      <= cfg_data;
        REG_PAYLOAD_LENGTH: payload_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (payload_length < LEN_MIN) begin
      eff_length = LEN_MIN;
    end else if (payload_length > LEN_MAX) begin
      eff_length = LEN_MAX;
    end else begin
      eff_length = payload_length;
    end
  end

  assign count_inc = byte_count + LEN_W'(1);

  // Payload bytes wait while an earlier frame still needs the store;
  // a tail byte waits for room in the queue.
  always_comb begin
    rx_stall = 1'b0;
    case (phase)
      PH_PAYLOAD: rx_stall = !q_status.empty || back_busy;
      PH_TAIL:    rx_stall = q_status.full;
      default:    rx_stall = 1'b0;
    endcase
  end

  assign accept     = rx_valid && !rx_stall;
  assign frame_good = (rx_byte == tail_byte) && sum_ok;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (phase)
        PH_HUNT:    if (rx_byte == head_byte) phase_next = PH_PAYLOAD;
        PH_PAYLOAD: if (count_inc >= eff_length) phase_next = PH_CHECK;
        PH_CHECK:   phase_next = PH_TAIL;
        PH_TAIL:    phase_next = PH_HUNT;
        default:    phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    push          = 1'b0;
    count_error   = 1'b0;
    store_wr.en   = 1'b0;
    store_wr.addr = byte_count[ADDR_W-1:0];
    store_wr.data = rx_byte;
    if (accept) begin
      case (phase)
        PH_HUNT:    count_error = (rx_byte != head_byte);
        PH_PAYLOAD: store_wr.en = 1'b1;
        PH_TAIL: begin
          push        = frame_good;
          count_error = !frame_good;
        end
        default: ;
      endcase
    end
  end

  assign push_cmd.count  = byte_count;
  assign push_cmd.errors = errors_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= '0;
      running_sum <= '0;
      sum_ok      <= 1'b0;
      errors_seen <= '0;
    end else begin
      phase <= phase_next;
      if (count_error && errors_seen != ERR_MAX) begin
        errors_seen <= errors_seen + ERR_W'(1);
      end
      if (accept) begin
        case (phase)
          PH_HUNT: begin
            byte_count  <= '0;
            running_sum <= '0;
            sum_ok      <= 1'b0;
          end
          PH_PAYLOAD: begin
            byte_count  <= count_inc;
            running_sum <= running_sum + rx_byte;
          end
          PH_CHECK: sum_ok <= (rx_byte == running_sum);
          PH_TAIL: begin
            byte_count  <= '0;
            running_sum <= '0;
            sum_ok      <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // The store is never written while a queued or draining frame needs it.
  a_store_free: assert property (@(posedge clk) disable iff (rst)
    store_wr.en |-> (q_status.empty && !back_busy))
    else $error("payload store written while a frame is pending");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("frame queued into a full queue");

  // A frame never holds more bytes than the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LEN_MAX)
    else $error("byte count beyond store depth");

endmodule

// ===== rtl/hcd_queue.sv =====
// ----------------------------------------------------------------------------
// hcd_queue
// Two-entry queue of verified frames between the front and the back.
// ----------------------------------------------------------------------------
module hcd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  hcd_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output hcd_pkg::cmd_t          head_cmd,
  output hcd_pkg::queue_status_t status
);
  import hcd_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign head_cmd     = entries[rd_ptr];
  assign status.empty = (fill == 2'd0);
  assign status.full  = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from an empty frame queue");

endmodule

// ===== rtl/hcd_back.sv =====
// ----------------------------------------------------------------------------
// hcd_back
// Owns the payload store and drains one queued frame at a time, reading each
// byte from the store and then loading it into the output register.
// ----------------------------------------------------------------------------
module hcd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  hcd_pkg::store_wr_t         store_wr,
  input  hcd_pkg::queue_status_t     q_status,
  input  hcd_pkg::cmd_t              head_cmd,
  output logic                       pop,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 data_byte,
  output logic [hcd_pkg::ADDR_W-1:0] byte_index,
  output logic                       last,
  output logic [hcd_pkg::ERR_W-1:0]  error_count
);
  import hcd_pkg::*;

  logic [7:0]       store [MAX_PAYLOAD];
  logic [7:0]       rd_data;

  back_state_t      state;
  back_state_t      state_next;
  logic [ADDR_W-1:0] idx;
  logic [LEN_W-1:0] count;
  logic [ERR_W-1:0] errors;
  logic             out_free;
  logic             load;
  logic             is_last;

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[store_wr.addr] <= store_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_READ) begin
      rd_data <= store[idx];
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign is_last  = ({1'b0, idx} + LEN_W'(1)) == count;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_status.empty) state_next = BK_READ;
      BK_READ: state_next = BK_LOAD;
      BK_LOAD: if (out_free) state_next = is_last ? BK_IDLE : BK_READ;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == BK_IDLE) && !q_status.empty;
    load = (state == BK_LOAD) && out_free;
    busy = (state != BK_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx    <= '0;
      count  <= head_cmd.count;
      errors <= head_cmd.errors;
    end else if (load) begin
      idx <= idx + ADDR_W'(1);
    end
    if (load) begin
      data_byte   <= rd_data;
      byte_index  <= idx;
      last        <= is_last;
      error_count <= errors;
    end
  end

  // While draining, the byte position stays inside the frame.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> ({1'b0, idx} < count))
    else $error("drain index beyond frame length");

  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    (state == BK_READ) |=> (state == BK_LOAD))
    else $error("store read not followed by a load");

endmodule

// ===== rtl/head_tail_checksum_deframer_top.sv =====
// ----------------------------------------------------------------------------
// head_tail_checksum_deframer_top
// Fixed-length frame deframer: head byte, payload, 8-bit sum, tail byte.
// ----------------------------------------------------------------------------
// The first payload byte of a verified frame reaches the output register
// after the tail byte's transaction, through the queue, store read and load.
// Throughput: received bytes are taken one per cycle while rx_stall is low;
// payload bytes of a new frame are held off while an earlier frame is queued
// or draining, and a tail byte waits for room in the queue. The drain
// sequencer reads the single-port store, then loads each byte for output.
// Reset (rst, synchronous, active high) returns the registers to their
// defaults, the deframer to head hunting and clears the error count and queue.
// ----------------------------------------------------------------------------
module head_tail_checksum_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic [4:0]  byte_index,
  output logic        last,
  output logic [15:0] error_count
);
  import hcd_pkg::*;

  // The front classifies every received byte: it hunts for the head, stores
  // the payload, checks the running sum and the tail, and counts rejected
  // bytes and frames. A verified frame becomes one queue entry carrying its
  // length and the error count at the moment its tail was accepted.
  store_wr_t     store_wr;
  cmd_t          push_cmd;
  cmd_t          head_cmd;
  queue_status_t q_status;
  logic          push;
  logic          pop;
  logic          back_busy;

  hcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_byte   (rx_byte),
    .q_status  (q_status),
    .back_busy (back_busy),
    .push      (push),
    .push_cmd  (push_cmd),
    .store_wr  (store_wr)
  );

  // The queue lets the front keep hunting and counting errors while the
  // back is still draining an earlier frame.
  hcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // The back owns the payload store and turns each queued frame into a run
  // of output transactions, the final one marked by last.
  hcd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .store_wr    (store_wr),
    .q_status    (q_status),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .busy        (back_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .byte_index  (byte_index),
    .last        (last),
    .error_count (error_count)
  );

endmodule
